// ===== sv/pvc_pkg.sv =====
// Shared types and constants of the pixel variance convergence block.
`timescale 1ns / 1ps

package pvc_pkg;

   localparam int PIXELS = 65536;
   localparam int ADDR_W = $clog2(PIXELS);
   localparam int NUM_CH = 3;
   localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

   localparam int ACC_W = 112;
   localparam int LIM_W = 79;

   localparam logic [5:0] DIV_STEPS = 6'd32;

   localparam logic [1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [1:0] CSR_MIN_SAMPLES = 2'd1;
   localparam logic [1:0] CSR_REL_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_ABS_FLOOR = 2'd3;

   localparam logic [8:0] ROW_WIDTH_RESET = 9'd256;
   localparam logic [15:0] MIN_SAMPLES_RESET = 16'd16;
   localparam logic [15:0] REL_THRESHOLD_RESET = 16'd655;
   localparam logic [39:0] ABS_FLOOR_RESET = 40'd281474977;

   typedef struct packed {
      logic done;
      logic [15:0] count;
      logic [NUM_CH-1:0][31:0] mean;
      logic [NUM_CH-1:0][63:0] m2;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      SH_0,
      SH_32,
      SH_64
   } shift_type;

   typedef struct packed {
      logic go;
      logic clr;
      shift_type shift;
   } mac_ctl_type;

   typedef enum logic [2:0] {
      OP_CSQ,
      OP_DEV,
      OP_MSQ,
      OP_LIM_LO,
      OP_LIM_HI,
      OP_RHS_LO,
      OP_RHS_MID,
      OP_RHS_HI
   } op_type;

endpackage

// ===== sv/pvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pvc_div.sv =====
// Restoring divider of a 32-bit magnitude by a 16-bit count, one bit per cycle.
`timescale 1ns / 1ps

module pvc_div import pvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign fits = trial >= {1'b0, den_ff};
   assign diff = trial - {1'b0, den_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/pvc_mac.sv =====
// Shared 32 by 32 multiplier with a registered product and a shifted wide accumulator.
`timescale 1ns / 1ps

module pvc_mac import pvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mac_ctl_type      ctl,
   input  logic [31:0]      op_a,
   input  logic [31:0]      op_b,
   input  logic [ACC_W-1:0] init,
   output logic [ACC_W-1:0] acc
);

   logic [63:0]      prod_ff;
   logic             pend_ff;
   logic             clr_ff;
   shift_type        shift_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] shifted;

   always_comb begin
      case (shift_ff)
         SH_0: shifted = {48'b0, prod_ff};
         SH_32: shifted = {16'b0, prod_ff, 32'b0};
         SH_64: shifted = {prod_ff[47:0], 64'b0};
         default: shifted = '0;
      endcase
   end

   assign acc_in = pend_ff ? ((clr_ff ? init : acc_ff) + shifted) : acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.go) begin
         prod_ff <= op_a * op_b;
         clr_ff <= ctl.clr;
         shift_ff <= ctl.shift;
      end
      acc_ff <= acc_in;
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctl.go;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== sv/pixel_variance_convergence.sv =====
// Top level: per-pixel Welford accumulator with exact convergence test.
// A sample item is worked channel by channel: per channel one
// 32-step divide of the delta by the count and eight passes through the shared multiplier.
// One item is in work at a time; the next is taken only once the last result is posted.
// A clear item sweeps all 65536 entries, one per cycle, before its result appears.
// Synchronous reset restores control and CSR registers and runs the same sweep, no item taken.
`timescale 1ns / 1ps

module pixel_variance_convergence import pvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [7:0]         req_pixel_x,
   input  logic [7:0]         req_pixel_y,
   input  logic signed [15:0] req_red,
   input  logic signed [15:0] req_green,
   input  logic signed [15:0] req_blue,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_sample_count,
   output logic               rsp_converged,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [39:0]        csr_data
);

   typedef enum logic [11:0] {
      S_CLR      = 12'b000000000001,
      S_IDLE     = 12'b000000000010,
      S_READ     = 12'b000000000100,
      S_LOAD     = 12'b000000001000,
      S_DIV_GO   = 12'b000000010000,
      S_DIV_WAIT = 12'b000000100000,
      S_NM       = 12'b000001000000,
      S_MUL      = 12'b000010000000,
      S_ACC      = 12'b000100000000,
      S_CHK      = 12'b001000000000,
      S_WRITE    = 12'b010000000000,
      S_RSP      = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [1:0] ch_ff, ch_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic [NUM_CH-1:0][15:0] samp_ff, samp_in;
   entry_type ent_ff, ent_in;
   logic ok_ff, ok_in;
   logic dneg_ff, dneg_in;
   logic [31:0] dmag_ff, dmag_in;
   logic [31:0] d2mag_ff, d2mag_in;
   logic [31:0] nmag_ff, nmag_in;
   logic [31:0] c2_ff, c2_in;
   logic [63:0] msq_ff, msq_in;
   logic [LIM_W-1:0] lim_ff, lim_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_count_ff, rsp_count_in;
   logic rsp_conv_ff, rsp_conv_in;

   logic [8:0] row_width_ff;
   logic [15:0] min_samples_ff;
   logic [15:0] rel_thr_ff;
   logic [39:0] abs_floor_ff;

   logic [16:0] idx_full;
   entry_type rd_ent;
   logic [ENTRY_W-1:0] rd_data;
   logic [15:0] count_new;
   logic [31:0] ch_mean;
   logic [27:0] s_val;
   logic [32:0] delta;
   logic [32:0] delta_neg;
   logic [31:0] quo;
   logic div_done;
   logic [33:0] q_signed;
   logic [33:0] nm_full;
   logic [31:0] nm;
   logic [32:0] delta2;
   logic [32:0] delta2_neg;
   logic [32:0] nm_neg;
   logic [64:0] m2_sum;
   logic [63:0] m2_sat;
   logic [ACC_W-1:0] lhs;
   logic [ACC_W-1:0] acc;
   logic [ACC_W-1:0] mac_init;
   mac_ctl_type mac_ctl;
   logic [31:0] mac_a;
   logic [31:0] mac_b;
   logic done_new;
   entry_type wr_ent;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic rd_en;

   assign idx_full = 17'(req_pixel_y) * 17'(row_width_ff) + 17'(req_pixel_x);
   assign rd_ent = entry_type'(rd_data);
   assign count_new = (rd_ent.count == 16'hFFFF) ? rd_ent.count : rd_ent.count + 16'd1;

   assign ch_mean = ent_ff.mean[ch_ff];
   assign s_val = {samp_ff[ch_ff], 12'b0};
   assign delta = {{5{s_val[27]}}, s_val} - {ch_mean[31], ch_mean};
   assign delta_neg = -delta;
   assign q_signed = dneg_ff ? -{2'b0, quo} : {2'b0, quo};
   assign nm_full = {{2{ch_mean[31]}}, ch_mean} + q_signed;
   assign nm = nm_full[31:0];
   assign delta2 = {{5{s_val[27]}}, s_val} - {nm[31], nm};
   assign delta2_neg = -delta2;
   assign nm_neg = -{nm[31], nm};

   assign m2_sum = {1'b0, ent_ff.m2[ch_ff]} + {1'b0, acc[63:0]};
   assign m2_sat = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
   assign lhs = {32'b0, ent_ff.m2[ch_ff], 16'b0};

   assign done_new = ent_ff.done | ((ent_ff.count >= min_samples_ff) & ok_ff);

   always_comb begin
      wr_ent = ent_ff;
      wr_ent.done = done_new;
   end

   assign mac_init = (op_ff == OP_LIM_LO) ? {56'b0, abs_floor_ff, 16'b0} : '0;

   always_comb begin
      mac_a = c2_ff;
      mac_b = '0;
      mac_ctl.clr = 1'b0;
      mac_ctl.shift = SH_0;
      case (op_ff)
         OP_CSQ: begin
            mac_a = {16'b0, ent_ff.count};
            mac_b = {16'b0, ent_ff.count};
            mac_ctl.clr = 1'b1;
         end
         OP_DEV: begin
            mac_a = dmag_ff;
            mac_b = d2mag_ff;
            mac_ctl.clr = 1'b1;
         end
         OP_MSQ: begin
            mac_a = nmag_ff;
            mac_b = nmag_ff;
            mac_ctl.clr = 1'b1;
         end
         OP_LIM_LO: begin
            mac_a = {16'b0, rel_thr_ff};
            mac_b = acc[31:0];
            mac_ctl.clr = 1'b1;
         end
         OP_LIM_HI: begin
            mac_a = {16'b0, rel_thr_ff};
            mac_b = msq_ff[63:32];
            mac_ctl.shift = SH_32;
         end
         OP_RHS_LO: begin
            mac_b = acc[31:0];
            mac_ctl.clr = 1'b1;
         end
         OP_RHS_MID: begin
            mac_b = lim_ff[63:32];
            mac_ctl.shift = SH_32;
         end
         OP_RHS_HI: begin
            mac_b = {17'b0, lim_ff[78:64]};
            mac_ctl.shift = SH_64;
         end
         default: begin
            mac_b = '0;
         end
      endcase
      mac_ctl.go = (state_ff == S_MUL);
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      ch_in = ch_ff;
      idx_in = idx_ff;
      clr_addr_in = clr_addr_ff;
      clr_rsp_in = clr_rsp_ff;
      samp_in = samp_ff;
      ent_in = ent_ff;
      ok_in = ok_ff;
      dneg_in = dneg_ff;
      dmag_in = dmag_ff;
      d2mag_in = d2mag_ff;
      nmag_in = nmag_ff;
      c2_in = c2_ff;
      msq_in = msq_ff;
      lim_in = lim_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_conv_in = rsp_conv_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = ENTRY_W'(wr_ent);
      rd_en = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               clr_rsp_in = 1'b0;
               state_in = clr_rsp_ff ? S_RSP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_command) begin
                  ent_in = '0;
                  clr_rsp_in = 1'b1;
                  clr_addr_in = '0;
                  state_in = S_CLR;
               end else begin
                  idx_in = idx_full[ADDR_W-1:0];
                  samp_in[0] = req_red;
                  samp_in[1] = req_green;
                  samp_in[2] = req_blue;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            ent_in = rd_ent;
            ent_in.count = count_new;
            ok_in = 1'b1;
            ch_in = '0;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            dneg_in = delta[32];
            dmag_in = delta[32] ? delta_neg[31:0] : delta[31:0];
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_NM;
            end
         end
         S_NM: begin
            ent_in.mean[ch_ff] = nm;
            d2mag_in = delta2[32] ? delta2_neg[31:0] : delta2[31:0];
            nmag_in = nm[31] ? nm_neg[31:0] : nm;
            op_in = OP_CSQ;
            state_in = S_MUL;
         end
         S_MUL: begin
            case (op_ff)
               OP_DEV: c2_in = acc[31:0];
               OP_MSQ: ent_in.m2[ch_ff] = m2_sat;
               OP_LIM_LO: msq_in = acc[63:0];
               OP_RHS_LO: lim_in = acc[LIM_W-1:0];
               default: c2_in = c2_ff;
            endcase
            state_in = S_ACC;
         end
         S_ACC: begin
            if (op_ff == OP_RHS_HI) begin
               state_in = S_CHK;
            end else begin
               op_in = op_type'(op_ff + 3'd1);
               state_in = S_MUL;
            end
         end
         S_CHK: begin
            ok_in = ok_ff & (lhs <= acc);
            if (ch_ff == CH_LAST) begin
               state_in = S_WRITE;
            end else begin
               ch_in = ch_ff + 2'd1;
               state_in = S_DIV_GO;
            end
         end
         S_WRITE: begin
            wr_en = 1'b1;
            ent_in.done = done_new;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = ent_ff.count;
               rsp_conv_in = ent_ff.done;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      samp_ff <= samp_in;
      ent_ff <= ent_in;
      ok_ff <= ok_in;
      dneg_ff <= dneg_in;
      dmag_ff <= dmag_in;
      d2mag_ff <= d2mag_in;
      nmag_ff <= nmag_in;
      c2_ff <= c2_in;
      msq_ff <= msq_in;
      lim_ff <= lim_in;
      rsp_count_ff <= rsp_count_in;
      rsp_conv_ff <= rsp_conv_in;
      op_ff <= op_in;
      if (reset) begin
         state_ff <= S_CLR;
         ch_ff <= '0;
         clr_addr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff <= ch_in;
         clr_addr_ff <= clr_addr_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         min_samples_ff <= MIN_SAMPLES_RESET;
         rel_thr_ff <= REL_THRESHOLD_RESET;
         abs_floor_ff <= ABS_FLOOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: row_width_ff <= csr_data[8:0];
            CSR_MIN_SAMPLES: min_samples_ff <= csr_data[15:0];
            CSR_REL_THRESHOLD: rel_thr_ff <= csr_data[15:0];
            CSR_ABS_FLOOR: abs_floor_ff <= csr_data;
            default: abs_floor_ff <= abs_floor_ff;
         endcase
      end
   end

   pvc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PIXELS)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   pvc_div u_div (
      .clock(clock),
      .reset(reset),
      .start(state_ff == S_DIV_GO),
      .dividend(delta[32] ? delta_neg[31:0] : delta[31:0]),
      .divisor(ent_ff.count),
      .done(div_done),
      .quotient(quo)
   );

   pvc_mac u_mac (
      .clock(clock),
      .reset(reset),
      .ctl(mac_ctl),
      .op_a(mac_a),
      .op_b(mac_b),
      .init(mac_init),
      .acc(acc)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_converged = rsp_conv_ff;

`ifndef NO_ASSERTIONS
   a_chk_after_last_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (op_ff == OP_RHS_HI))
      else $error("Convergence check entered before the last multiply.");
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (ch_ff <= CH_LAST))
      else $error("Channel counter out of range.");
   a_rsp_from_rsp_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RSP))
      else $error("Result raised outside the result state.");
`endif

endmodule
